// File: hdl/integer_matrix_engine_assert.svh
// ----------------------------------------------------------------------------
// integer_matrix_engine assertion macros
// Same-cycle and next-cycle implication checks, clocked, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_ENGINE_ASSERT_SVH
`define INTEGER_MATRIX_ENGINE_ASSERT_SVH

// same-cycle implication
`define IME_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IME_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ime_pkg.sv
// ----------------------------------------------------------------------------
// ime_pkg
// Shared types and codes of the integer matrix engine.
// ----------------------------------------------------------------------------
package ime_pkg;

    localparam int DATA_W  = 32;
    localparam int DIM_W   = 4;
    localparam int IDX_W   = 3;
    localparam int POS_W   = 7;
    localparam int PADDR_W = 5;

    localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_TRN = 2'd2;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] element;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic                     last;
        logic                     dim_error;
    } res_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] cols_a;
        logic [DIM_W-1:0] rows_b;
        logic [DIM_W-1:0] cols_b;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic       load_prod;
        logic       load_acc;
        logic       first;
    } mac_ctl_t;

endpackage

// File: hdl/ime_store.sv
// ----------------------------------------------------------------------------
// ime_store
// Matrix element store: sequential fill, registered read, unwritten reads zero.
// ----------------------------------------------------------------------------
module ime_store
    import ime_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [POS_W-1:0]  rd_pos,
    output logic [DATA_W-1:0] rd_data
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [DATA_W-1:0] data_reg;
    logic              hit_reg;
    logic              do_write;

    assign do_write = wr_en && (fill_reg < FILL_W'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (do_write)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (rd_en)
            begin
                hit_reg <= rd_pos < POS_W'(fill_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_pos[ADDR_W-1:0]];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

// File: hdl/ime_mac.sv
// ----------------------------------------------------------------------------
// ime_mac
// Shared arithmetic unit: add, multiply or pass, then accumulate, mod 2^32.
// ----------------------------------------------------------------------------
module ime_mac
    import ime_pkg::*;
(
    input  logic              clk,
    input  mac_ctl_t          ctl,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [DATA_W-1:0] value
);

    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] prod_next;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_base;

    always_comb
    begin
        unique case (ctl.op)
            OP_ADD:  prod_next = a + b;
            OP_MUL:  prod_next = a * b;
            default: prod_next = a;
        endcase
    end

    assign acc_base = ctl.first ? '0 : acc_reg;
    assign value    = acc_base + prod_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_prod)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.load_acc)
        begin
            acc_reg <= value;
        end
    end

endmodule

// File: hdl/ime_seq.sv
// ----------------------------------------------------------------------------
// ime_seq
// Sequencer: dimension check, index walk, store addressing, result register.
// ----------------------------------------------------------------------------
module ime_seq
    import ime_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              cmd_valid,
    input  logic [1:0]        cmd_func,
    output logic              cmd_stall,
    output logic              rd_en,
    output logic [POS_W-1:0]  pos_a,
    output logic [POS_W-1:0]  pos_b,
    output mac_ctl_t          mac_ctl,
    input  logic [DATA_W-1:0] mac_value,
    output logic              res_valid,
    input  logic              res_stall,
    output res_t              res
);

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_OPER,
        S_ACC,
        S_ERR
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] k_reg;
    logic             res_valid_reg;
    res_t             res_reg;

    logic             dims_ok;
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nc;
    logic             is_mul;
    logic             i_end;
    logic             j_end;
    logic             k_end;
    logic             elem_last;
    logic             res_free;
    logic             res_load;
    logic             compute_take;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] ca;
    logic [IDX_W-1:0] rb;
    logic [IDX_W-1:0] cb;

    function automatic logic dim_ok(input logic [DIM_W-1:0] d);
        return (d != '0) && (d <= DIM_MAX);
    endfunction

    always_comb
    begin
        unique case (cfg.operation)
            OP_ADD:
            begin
                dims_ok = dim_ok(cfg.rows_a) && dim_ok(cfg.cols_a)
                          && (cfg.rows_a == cfg.rows_b) && (cfg.cols_a == cfg.cols_b);
                nr = cfg.rows_a;
                nc = cfg.cols_a;
            end
            OP_MUL:
            begin
                dims_ok = dim_ok(cfg.rows_a) && dim_ok(cfg.cols_a)
                          && dim_ok(cfg.rows_b) && dim_ok(cfg.cols_b)
                          && (cfg.cols_a == cfg.rows_b);
                nr = cfg.rows_a;
                nc = cfg.cols_b;
            end
            OP_TRN:
            begin
                dims_ok = dim_ok(cfg.rows_a) && dim_ok(cfg.cols_a);
                nr = cfg.cols_a;
                nc = cfg.rows_a;
            end
            default:
            begin
                dims_ok = 1'b0;
                nr = '0;
                nc = '0;
            end
        endcase
    end

    always_comb
    begin
        unique case (cfg.operation)
            OP_MUL:
            begin
                ra = i_reg;
                ca = k_reg;
                rb = k_reg;
                cb = j_reg;
            end
            OP_TRN:
            begin
                ra = j_reg;
                ca = i_reg;
                rb = i_reg;
                cb = j_reg;
            end
            default:
            begin
                ra = i_reg;
                ca = j_reg;
                rb = i_reg;
                cb = j_reg;
            end
        endcase
    end

    assign pos_a = POS_W'(ra) * POS_W'(cfg.cols_a) + POS_W'(ca);
    assign pos_b = POS_W'(rb) * POS_W'(cfg.cols_b) + POS_W'(cb);

    assign is_mul    = cfg.operation == OP_MUL;
    assign i_end     = (DIM_W'(i_reg) + 4'd1) == nr;
    assign j_end     = (DIM_W'(j_reg) + 4'd1) == nc;
    assign k_end     = (DIM_W'(k_reg) + 4'd1) == cfg.cols_a;
    assign elem_last = i_end && j_end;
    assign res_free  = !res_valid_reg || !res_stall;
    assign res_load  = res_free && (((state_reg == S_ACC) && !(is_mul && !k_end))
                                    || (state_reg == S_ERR));

    assign cmd_stall    = state_reg != S_IDLE;
    assign compute_take = cmd_valid && (state_reg == S_IDLE) && (cmd_func == FUNC_COMPUTE);
    assign rd_en        = state_reg == S_READ;

    assign mac_ctl.op        = cfg.operation;
    assign mac_ctl.load_prod = state_reg == S_OPER;
    assign mac_ctl.load_acc  = (state_reg == S_ACC) && is_mul && !k_end;
    assign mac_ctl.first     = k_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_valid_reg && !res_stall && !res_load)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (compute_take)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= dims_ok ? S_READ : S_ERR;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_OPER;
                end
                S_OPER:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (is_mul && !k_end)
                    begin
                        k_reg     <= k_reg + IDX_W'(1);
                        state_reg <= S_READ;
                    end
                    else if (res_free)
                    begin
                        res_reg.value     <= mac_value;
                        res_reg.row       <= i_reg;
                        res_reg.col       <= j_reg;
                        res_reg.last      <= elem_last;
                        res_reg.dim_error <= 1'b0;
                        res_valid_reg     <= 1'b1;
                        k_reg             <= '0;
                        if (j_end)
                        begin
                            j_reg <= '0;
                            i_reg <= i_reg + IDX_W'(1);
                        end
                        else
                        begin
                            j_reg <= j_reg + IDX_W'(1);
                        end
                        state_reg <= elem_last ? S_IDLE : S_READ;
                    end
                end
                S_ERR:
                begin
                    if (res_free)
                    begin
                        res_reg.value     <= '0;
                        res_reg.row       <= '0;
                        res_reg.col       <= '0;
                        res_reg.last      <= 1'b1;
                        res_reg.dim_error <= 1'b1;
                        res_valid_reg     <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: hdl/integer_matrix_engine.sv
// ----------------------------------------------------------------------------
// integer_matrix_engine
// Loads matrices A and B, then emits A+B, A*B or transpose(A) row-major.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload    Handshake
// cmd      in   cmd_t      cmd_valid / cmd_stall
// res      out  res_t      res_valid / res_stall
// apb      in   registers  psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// Load transfers leave the sequencer idle; cmd_stall stays low between them.
// Compute: each result element walks S_READ, S_OPER and S_ACC, once for add and
// transpose and once per k for multiply, set by the single registered read port
// per store and the shared MAC with its product register; errors come from S_ERR.
// cmd_stall is high from the compute transfer until the final result is loaded
// into the output register; a stalled result holds the sequencer.
// No clearing pass after reset: fill counts mask entries never loaded.
// ----------------------------------------------------------------------------
`include "integer_matrix_engine_assert.svh"

module integer_matrix_engine
    import ime_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cmd_t               cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output res_t               res
);

    localparam int CAPACITY = MAX_DIM * MAX_DIM;

    localparam logic [2:0] REG_OPERATION = 3'd0;
    localparam logic [2:0] REG_ROWS_A    = 3'd1;
    localparam logic [2:0] REG_COLS_A    = 3'd2;
    localparam logic [2:0] REG_ROWS_B    = 3'd3;
    localparam logic [2:0] REG_COLS_B    = 3'd4;

    logic [1:0]       operation_reg;
    logic [DIM_W-1:0] rows_a_reg;
    logic [DIM_W-1:0] cols_a_reg;
    logic [DIM_W-1:0] rows_b_reg;
    logic [DIM_W-1:0] cols_b_reg;

    logic [2:0]        reg_idx;
    logic              cfg_wr;
    cfg_t              cfg;
    logic              cmd_take;
    logic              wr_a;
    logic              wr_b;
    logic              rd_en;
    logic [POS_W-1:0]  pos_a;
    logic [POS_W-1:0]  pos_b;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
    mac_ctl_t          mac_ctl;
    logic [DATA_W-1:0] mac_value;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg <= OP_ADD;
            rows_a_reg    <= DIM_W'(1);
            cols_a_reg    <= DIM_W'(1);
            rows_b_reg    <= DIM_W'(1);
            cols_b_reg    <= DIM_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_OPERATION: operation_reg <= pwdata[1:0];
                REG_ROWS_A:    rows_a_reg    <= pwdata[DIM_W-1:0];
                REG_COLS_A:    cols_a_reg    <= pwdata[DIM_W-1:0];
                REG_ROWS_B:    rows_b_reg    <= pwdata[DIM_W-1:0];
                REG_COLS_B:    cols_b_reg    <= pwdata[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_OPERATION: prdata = 32'(operation_reg);
            REG_ROWS_A:    prdata = 32'(rows_a_reg);
            REG_COLS_A:    prdata = 32'(cols_a_reg);
            REG_ROWS_B:    prdata = 32'(rows_b_reg);
            REG_COLS_B:    prdata = 32'(cols_b_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.operation = operation_reg;
    assign cfg.rows_a    = rows_a_reg;
    assign cfg.cols_a    = cols_a_reg;
    assign cfg.rows_b    = rows_b_reg;
    assign cfg.cols_b    = cols_b_reg;

    assign cmd_take = cmd_valid && !cmd_stall;
    assign wr_a     = cmd_take && (cmd.func == FUNC_LOAD_A);
    assign wr_b     = cmd_take && (cmd.func == FUNC_LOAD_B);

    ime_store #(
        .DEPTH (CAPACITY)
    ) u_store_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_a),
        .wr_data (cmd.element),
        .rd_en   (rd_en),
        .rd_pos  (pos_a),
        .rd_data (rd_a)
    );

    ime_store #(
        .DEPTH (CAPACITY)
    ) u_store_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_b),
        .wr_data (cmd.element),
        .rd_en   (rd_en),
        .rd_pos  (pos_b),
        .rd_data (rd_b)
    );

    ime_mac u_mac (
        .clk   (clk),
        .ctl   (mac_ctl),
        .a     (rd_a),
        .b     (rd_b),
        .value (mac_value)
    );

    ime_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_func  (cmd.func),
        .cmd_stall (cmd_stall),
        .rd_en     (rd_en),
        .pos_a     (pos_a),
        .pos_b     (pos_b),
        .mac_ctl   (mac_ctl),
        .mac_value (mac_value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    `IME_ASSERT_NXT(a_load_no_stall, clk, rst_n, cmd_take && (cmd.func != FUNC_COMPUTE), !cmd_stall, "non-compute transfer left the block busy")
    `IME_ASSERT_NXT(a_compute_busy, clk, rst_n, cmd_take && (cmd.func == FUNC_COMPUTE), cmd_stall, "compute transfer did not start a run")
    `IME_ASSERT_IMP(a_error_shape, clk, rst_n, res_valid && res.dim_error, res.last && (res.value == '0) && (res.row == '0) && (res.col == '0), "malformed error result")

endmodule

// File: bench/integer_matrix_engine_tb.sv
// ----------------------------------------------------------------------------
// integer_matrix_engine_tb
// Loads matrices A and B through the command channel. Computes sums, products
// and transposes under many register settings, including bad dimensions.
// Every result transfer is checked against a matrix predictor kept in the
// bench. The command channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module integer_matrix_engine_tb;
    import ime_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM        = 8;
    localparam int CAPACITY       = MAX_DIM * MAX_DIM;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [1:0] OP_UNKNOWN  = 2'd3;

    localparam int REG_OPERATION = 0;
    localparam int REG_ROWS_A    = 1;
    localparam int REG_COLS_A    = 2;
    localparam int REG_ROWS_B    = 3;
    localparam int REG_COLS_B    = 4;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    cmd_t               cmd       = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    res_t               res;

    // matrix predictor state
    logic [31:0] shadow_a [CAPACITY];
    logic [31:0] shadow_b [CAPACITY];
    int unsigned count_a;
    int unsigned count_b;
    cfg_t        model_cfg;

    cmd_t queued_commands [$];
    res_t result_elements_due [$];

    int unsigned planned_a;
    int unsigned planned_b;
    int          gap_left;
    int          stall_left;
    int          idle_cycles;
    int          mismatches;
    logic        quiet      = 1'b0;
    logic        hold_armed = 1'b0;

    integer_matrix_engine DUT (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit dim_ok(input logic [DIM_W-1:0] d);
        return d >= 1 && d <= MAX_DIM;
    endfunction

    function automatic logic [31:0] read_a(input int unsigned r, input int unsigned c);
        int unsigned pos;
        pos = r * model_cfg.cols_a + c;
        if (pos >= CAPACITY)
            return '0;
        return shadow_a[pos];
    endfunction

    function automatic logic [31:0] read_b(input int unsigned r, input int unsigned c);
        int unsigned pos;
        pos = r * model_cfg.cols_b + c;
        if (pos >= CAPACITY)
            return '0;
        return shadow_b[pos];
    endfunction

    task automatic apply_matrix_command(input cmd_t c);
        int unsigned nr;
        int unsigned nc;
        bit          ok;
        logic [31:0] acc;
        res_t        r;
        case (c.func)
            FUNC_LOAD_A:
            begin
                if (count_a < CAPACITY)
                begin
                    shadow_a[count_a] = c.element;
                    count_a++;
                end
            end
            FUNC_LOAD_B:
            begin
                if (count_b < CAPACITY)
                begin
                    shadow_b[count_b] = c.element;
                    count_b++;
                end
            end
            FUNC_COMPUTE:
            begin
                ok = 1'b0;
                nr = 0;
                nc = 0;
                case (model_cfg.operation)
                    OP_ADD:
                    begin
                        ok = dim_ok(model_cfg.rows_a) && dim_ok(model_cfg.cols_a)
                             && model_cfg.rows_a == model_cfg.rows_b
                             && model_cfg.cols_a == model_cfg.cols_b;
                        nr = model_cfg.rows_a;
                        nc = model_cfg.cols_a;
                    end
                    OP_MUL:
                    begin
                        ok = dim_ok(model_cfg.rows_a) && dim_ok(model_cfg.cols_a)
                             && dim_ok(model_cfg.rows_b) && dim_ok(model_cfg.cols_b)
                             && model_cfg.cols_a == model_cfg.rows_b;
                        nr = model_cfg.rows_a;
                        nc = model_cfg.cols_b;
                    end
                    OP_TRN:
                    begin
                        ok = dim_ok(model_cfg.rows_a) && dim_ok(model_cfg.cols_a);
                        nr = model_cfg.cols_a;
                        nc = model_cfg.rows_a;
                    end
                    default:
                        ok = 1'b0;
                endcase
                if (!ok)
                begin
                    r = '0;
                    r.last = 1'b1;
                    r.dim_error = 1'b1;
                    result_elements_due.push_back(r);
                end
                else
                begin
                    for (int unsigned i = 0; i < nr; i++)
                    begin
                        for (int unsigned j = 0; j < nc; j++)
                        begin
                            case (model_cfg.operation)
                                OP_ADD:
                                    acc = read_a(i, j) + read_b(i, j);
                                OP_MUL:
                                begin
                                    acc = '0;
                                    for (int unsigned k = 0; k < model_cfg.cols_a; k++)
                                        acc += read_a(i, k) * read_b(k, j);
                                end
                                default:
                                    acc = read_a(j, i);
                            endcase
                            r.value = acc;
                            r.row = 3'(i);
                            r.col = 3'(j);
                            r.last = (i + 1 == nr && j + 1 == nc);
                            r.dim_error = 1'b0;
                            result_elements_due.push_back(r);
                        end
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (result_elements_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected result: value=%0d row=%0d col=%0d last=%0b err=%0b",
                         got.value, got.row, got.col, got.last, got.dim_error);
        end
        else
        begin
            want = result_elements_due.pop_front();
            if (got.value !== want.value || got.row !== want.row || got.col !== want.col
                || got.last !== want.last || got.dim_error !== want.dim_error)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result mismatch: expected value=%0d row=%0d col=%0d last=%0b err=%0b, got value=%0d row=%0d col=%0d last=%0b err=%0b",
                             want.value, want.row, want.col, want.last, want.dim_error,
                             got.value, got.row, got.col, got.last, got.dim_error);
            end
        end
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                apply_matrix_command(cmd);
            if (!cmd_valid || !cmd_stall)
            begin
                if (gap_left > 0)
                begin
                    cmd_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (queued_commands.size() > 0)
                begin
                    cmd <= queued_commands.pop_front();
                    cmd_valid <= 1'b1;
                    gap_left <= quiet ? 0 : pick_gap();
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
                check_result(res);
            if (hold_armed && res_valid && stall_left == 0)
            begin
                res_stall <= 1'b1;
                stall_left <= LONG_HOLD;
                hold_armed <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                res_stall <= 1'b0;
                if (!quiet && $urandom_range(0, 3) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_register(input int idx, input logic [DIM_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * idx);
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_OPERATION: model_cfg.operation = value[1:0];
            REG_ROWS_A:    model_cfg.rows_a = value;
            REG_COLS_A:    model_cfg.cols_a = value;
            REG_ROWS_B:    model_cfg.rows_b = value;
            REG_COLS_B:    model_cfg.cols_b = value;
            default:       ;
        endcase
    endtask

    task automatic set_registers(input logic [1:0] op, input logic [DIM_W-1:0] ra,
                                 input logic [DIM_W-1:0] ca, input logic [DIM_W-1:0] rb,
                                 input logic [DIM_W-1:0] cb);
        write_register(REG_OPERATION, DIM_W'(op));
        write_register(REG_ROWS_A, ra);
        write_register(REG_COLS_A, ca);
        write_register(REG_ROWS_B, rb);
        write_register(REG_COLS_B, cb);
    endtask

    task automatic push_command(input logic [1:0] func, input logic [31:0] element);
        cmd_t c;
        c.func = func;
        c.element = element;
        queued_commands.push_back(c);
        if (func == FUNC_LOAD_A)
            planned_a++;
        if (func == FUNC_LOAD_B)
            planned_b++;
    endtask

    // sampled mid-cycle so the driver's pop and valid update are both visible
    task automatic drain();
        while (queued_commands.size() != 0 || cmd_valid || result_elements_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] random_element();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        return ($urandom_range(0, 5) == 0) ? DIM_W'(MAX_DIM) : DIM_W'($urandom_range(1, 4));
    endfunction

    initial
    begin
        logic [1:0]       op;
        logic [DIM_W-1:0] ra;
        logic [DIM_W-1:0] ca;
        logic [DIM_W-1:0] rb;
        logic [DIM_W-1:0] cb;
        logic [DIM_W-1:0] bad;
        int               kind;
        int               sel;

        foreach (shadow_a[i])
        begin
            shadow_a[i] = '0;
            shadow_b[i] = '0;
        end
        count_a = 0;
        count_b = 0;
        planned_a = 0;
        planned_b = 0;
        mismatches = 0;
        idle_cycles = 0;
        model_cfg = '{operation: OP_ADD, rows_a: 1, cols_a: 1, rows_b: 1, cols_b: 1};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: 1x1 sum of empty stores, then wrap on overflow
        push_command(FUNC_COMPUTE, 32'h0);
        push_command(FUNC_LOAD_A, 32'h7fff_ffff);
        push_command(FUNC_LOAD_B, 32'h0000_0001);
        push_command(FUNC_COMPUTE, 32'hffff_ffff);
        push_command(FUNC_UNUSED, 32'hffff_ffff);
        drain();

        set_registers(OP_MUL, 1, 2, 2, 1);
        push_command(FUNC_LOAD_A, 32'h8000_0000);
        push_command(FUNC_LOAD_B, 32'hffff_ffff);
        push_command(FUNC_COMPUTE, 32'h5555_aaaa);
        drain();

        set_registers(OP_TRN, 2, 1, 1, 1);
        push_command(FUNC_COMPUTE, 32'h0);
        drain();

        set_registers(OP_UNKNOWN, 1, 1, 1, 1);
        push_command(FUNC_COMPUTE, 32'h0);
        drain();

        set_registers(OP_ADD, 2, 2, 2, 3);
        push_command(FUNC_COMPUTE, 32'h0);
        drain();

        set_registers(OP_MUL, 2, 3, 2, 3);
        push_command(FUNC_COMPUTE, 32'h0);
        drain();

        set_registers(OP_TRN, 0, 4, 1, 1);
        push_command(FUNC_COMPUTE, 32'h0);
        drain();

        set_registers(OP_ADD, 15, 1, 15, 1);
        push_command(FUNC_COMPUTE, 32'h0);
        drain();

        // full-size product over partly loaded stores; receiver holds off
        // while further loads wait behind the compute
        set_registers(OP_MUL, 8, 8, 8, 8);
        hold_armed <= 1'b1;
        push_command(FUNC_COMPUTE, 32'h0);
        push_command(FUNC_LOAD_A, $urandom);
        push_command(FUNC_LOAD_B, $urandom);
        push_command(FUNC_LOAD_A, 32'h0);
        drain();

        for (int p = 0; p < 10; p++)
        begin
            kind = $urandom_range(0, 9);
            op = 2'($urandom_range(0, 2));
            ra = pick_dim();
            ca = pick_dim();
            rb = DIM_W'($urandom_range(1, 15));
            cb = DIM_W'($urandom_range(1, 15));
            if (op == OP_ADD)
            begin
                rb = ra;
                cb = ca;
            end
            else if (op == OP_MUL)
            begin
                rb = ca;
                cb = pick_dim();
            end
            if (kind == 7)
            begin
                op = OP_UNKNOWN;
            end
            else if (kind == 8)
            begin
                op = 2'($urandom_range(0, 1));
                rb = ra;
                cb = ca;
                if (op == OP_ADD)
                    cb = DIM_W'(ca % MAX_DIM + 1);
                else
                    rb = DIM_W'(ca % MAX_DIM + 1);
            end
            else if (kind == 9)
            begin
                bad = $urandom_range(0, 1) ? DIM_W'(0) : DIM_W'($urandom_range(9, 15));
                if ($urandom_range(0, 1))
                    ra = bad;
                else
                    ca = bad;
                if (op == OP_ADD)
                begin
                    rb = ra;
                    cb = ca;
                end
            end
            set_registers(op, ra, ca, rb, cb);
            quiet <= ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(6, 12))
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    push_command(FUNC_UNUSED, $urandom);
                else
                    push_command(sel[0] ? FUNC_LOAD_B : FUNC_LOAD_A, random_element());
            end
            push_command(FUNC_COMPUTE, $urandom);
            if ($urandom_range(0, 2) == 0)
                push_command(FUNC_COMPUTE, $urandom);
            drain();
        end
        quiet <= 1'b0;

        // fill both stores, then push past capacity
        set_registers(OP_ADD, 8, 8, 8, 8);
        while (planned_a < CAPACITY + 3 || planned_b < CAPACITY + 3)
        begin
            if (planned_a < CAPACITY + 3)
                push_command(FUNC_LOAD_A, random_element());
            if (planned_b < CAPACITY + 3)
                push_command(FUNC_LOAD_B, random_element());
        end
        push_command(FUNC_COMPUTE, 32'h0);
        drain();

        set_registers(OP_MUL, 8, 8, 8, 8);
        push_command(FUNC_COMPUTE, 32'h0);
        drain();

        set_registers(OP_TRN, 8, 8, 1, 1);
        push_command(FUNC_COMPUTE, 32'h0);
        drain();

        if (mismatches == 0 && result_elements_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
